### hdl/dsg_pkg.sv
// Shared types, codes and constants for the detection speed governor.
package dsg_pkg;

  localparam int HOLD_COUNT_WIDTH = 16;
  localparam int TICKS_W          = 16;
  localparam int SPEED_W          = 8;
  localparam int CMP_W            = (HOLD_COUNT_WIDTH > TICKS_W) ? HOLD_COUNT_WIDTH : TICKS_W;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 16;

  localparam logic [TICKS_W-1:0] STOP_HOLD_RESET   = TICKS_W'(2000);
  localparam logic [TICKS_W-1:0] BUMP_HOLD_RESET   = TICKS_W'(4000);
  localparam logic [SPEED_W-1:0] BUMP_SPEED_RESET  = SPEED_W'(30);
  localparam logic [SPEED_W-1:0] LOW_SPEED_RESET   = SPEED_W'(36);
  localparam logic [SPEED_W-1:0] NORMAL_SPEED_RESET = SPEED_W'(60);
  localparam logic [SPEED_W-1:0] SPEED_AT_RESET    = SPEED_W'(60);

  typedef logic [HOLD_COUNT_WIDTH-1:0] hold_count_t;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_STATUS = 2'd1,
    FUNC_SIGN   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    US_CLEAR      = 2'd0,
    US_PEDESTRIAN = 2'd1,
    US_ABNORMAL   = 2'd2,
    US_IGNORED    = 2'd3
  } us_status_t;

  typedef enum logic [2:0] {
    SIGN_NONE   = 3'd0,
    SIGN_STOP   = 3'd1,
    SIGN_BUMP   = 3'd2,
    SIGN_LOW    = 3'd3,
    SIGN_NORMAL = 3'd4
  } sign_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STOP_HOLD    = 3'd0,
    REG_BUMP_HOLD    = 3'd1,
    REG_BUMP_SPEED   = 3'd2,
    REG_LOW_SPEED    = 3'd3,
    REG_NORMAL_SPEED = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [TICKS_W-1:0] stop_hold_ticks;
    logic [TICKS_W-1:0] bump_hold_ticks;
    logic [SPEED_W-1:0] bump_speed;
    logic [SPEED_W-1:0] low_speed;
    logic [SPEED_W-1:0] normal_speed;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] us_status;
    logic [2:0] sign_class;
  } item_t;

endpackage

### hdl/detection_speed_governor.sv
// Top level of the detection speed governor: input register, core and result register.
//
//  channel | direction | fields
//  in_     | slave     | tuser: func; tdata: us_status, sign_class
//  out_    | master    | tdata: req_speed (one beat per tick)
//  cfg_    | slave     | cfg_index selects the register, cfg_data is the value
//
// One input beat is taken per cycle while the output is not stalled; a beat is held in the
// input register while the core works on it; a tick's speed then goes to the result register.
// Reset is synchronous on rst_n and restores every state and control register.
// A stalled output register holds its beat and stops the input register advancing;
// in_tready is then low once the input register holds a beat. cfg_ready is always high.
module detection_speed_governor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [1:0] us_status, [4:2] sign_class
  input  logic [1:0]                       in_tuser,   // [1:0] func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] req_speed
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dsg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dsg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dsg_pkg::cfg_t  cfg;
  dsg_pkg::item_t item_r, item_nxt;
  logic           in_valid_r, in_valid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_data_r, out_data_nxt;
  logic           out_free;
  logic           step;
  logic           res_valid;
  logic [dsg_pkg::SPEED_W-1:0] res_speed;

  assign cfg_ready = 1'b1;

  dsg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_comb begin
    item_nxt     = item_r;
    in_valid_nxt = in_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
      item_nxt.func       = in_tuser;
      item_nxt.us_status  = in_tdata[1:0];
      item_nxt.sign_class = in_tdata[4:2];
    end
  end

  dsg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_speed (res_speed)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/dsg_cfg_regs.sv
// Configuration register file of the detection speed governor.
module dsg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [dsg_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [dsg_pkg::CFG_DATA_W-1:0]   wr_data,
  output dsg_pkg::cfg_t                    cfg
);

  dsg_pkg::cfg_t cfg_r;
  dsg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (dsg_pkg::reg_index_t'(wr_index))
        dsg_pkg::REG_STOP_HOLD:    cfg_nxt.stop_hold_ticks = wr_data;
        dsg_pkg::REG_BUMP_HOLD:    cfg_nxt.bump_hold_ticks = wr_data;
        dsg_pkg::REG_BUMP_SPEED:   cfg_nxt.bump_speed   = wr_data[dsg_pkg::SPEED_W-1:0];
        dsg_pkg::REG_LOW_SPEED:    cfg_nxt.low_speed    = wr_data[dsg_pkg::SPEED_W-1:0];
        dsg_pkg::REG_NORMAL_SPEED: cfg_nxt.normal_speed = wr_data[dsg_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_hold_ticks <= dsg_pkg::STOP_HOLD_RESET;
      cfg_r.bump_hold_ticks <= dsg_pkg::BUMP_HOLD_RESET;
      cfg_r.bump_speed      <= dsg_pkg::BUMP_SPEED_RESET;
      cfg_r.low_speed       <= dsg_pkg::LOW_SPEED_RESET;
      cfg_r.normal_speed    <= dsg_pkg::NORMAL_SPEED_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/dsg_core.sv
// Speed decision logic and governor state, updated once per processed beat.
module dsg_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  dsg_pkg::item_t                item,
  input  dsg_pkg::cfg_t                 cfg,
  output logic                          res_valid,
  output logic [dsg_pkg::SPEED_W-1:0]   res_speed
);

  logic [dsg_pkg::SPEED_W-1:0] speed_now_r,  speed_now_nxt;
  logic [dsg_pkg::SPEED_W-1:0] saved_obs_r,  saved_obs_nxt;
  logic [dsg_pkg::SPEED_W-1:0] saved_stop_r, saved_stop_nxt;
  logic [dsg_pkg::SPEED_W-1:0] saved_bump_r, saved_bump_nxt;
  dsg_pkg::hold_count_t        hold_count_r, hold_count_nxt;
  logic [1:0]                  status_r,     status_nxt;
  logic [2:0]                  sign_r,       sign_nxt;

  logic                        is_stop;
  logic [dsg_pkg::TICKS_W-1:0] hold_limit;
  logic [dsg_pkg::SPEED_W-1:0] hold_speed;
  logic [dsg_pkg::SPEED_W-1:0] hold_saved;
  logic [dsg_pkg::SPEED_W-1:0] hold_saved_new;
  logic                        hold_active;

  // Both timed holds share one counter and compare; the sign picks the operands.
  always_comb begin
    is_stop    = (dsg_pkg::sign_t'(sign_r) == dsg_pkg::SIGN_STOP);
    hold_limit = is_stop ? cfg.stop_hold_ticks : cfg.bump_hold_ticks;
    hold_speed = is_stop ? '0 : cfg.bump_speed;
    hold_saved = is_stop ? saved_stop_r : saved_bump_r;
    hold_saved_new = ((speed_now_r != hold_speed) && (hold_count_r == '0)) ?
                     speed_now_r : hold_saved;
    hold_active = (dsg_pkg::CMP_W'(hold_count_r) < dsg_pkg::CMP_W'(hold_limit));
  end

  always_comb begin
    speed_now_nxt  = speed_now_r;
    saved_obs_nxt  = saved_obs_r;
    saved_stop_nxt = saved_stop_r;
    saved_bump_nxt = saved_bump_r;
    hold_count_nxt = hold_count_r;
    status_nxt     = status_r;
    sign_nxt       = sign_r;
    res_valid      = 1'b0;

    if (step) begin
      case (dsg_pkg::func_t'(item.func))
        dsg_pkg::FUNC_STATUS: status_nxt = item.us_status;
        dsg_pkg::FUNC_SIGN: begin
          sign_nxt       = item.sign_class;
          hold_count_nxt = '0;
        end
        dsg_pkg::FUNC_TICK: begin
          res_valid = 1'b1;
          if (dsg_pkg::us_status_t'(status_r) == dsg_pkg::US_ABNORMAL) begin
            speed_now_nxt = '0;
          end else if (dsg_pkg::us_status_t'(status_r) == dsg_pkg::US_PEDESTRIAN) begin
            if (speed_now_r != '0) saved_obs_nxt = speed_now_r;
            speed_now_nxt = '0;
          end else if (saved_obs_r == '0) begin
            case (dsg_pkg::sign_t'(sign_r))
              dsg_pkg::SIGN_STOP, dsg_pkg::SIGN_BUMP: begin
                if (is_stop) saved_stop_nxt = hold_saved_new;
                else         saved_bump_nxt = hold_saved_new;
                if (hold_active) begin
                  speed_now_nxt = hold_speed;
                  if (hold_count_r != '1) hold_count_nxt = hold_count_r + 1'b1;
                end else begin
                  speed_now_nxt = hold_saved_new;
                end
              end
              dsg_pkg::SIGN_LOW:    speed_now_nxt = cfg.low_speed;
              dsg_pkg::SIGN_NORMAL: speed_now_nxt = cfg.normal_speed;
              default: ;
            endcase
          end else if (dsg_pkg::us_status_t'(status_r) == dsg_pkg::US_CLEAR) begin
            // Obstacle gone: bring back the speed saved when it appeared.
            speed_now_nxt = saved_obs_r;
            saved_obs_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_now_r  <= dsg_pkg::SPEED_AT_RESET;
      saved_obs_r  <= '0;
      saved_stop_r <= '0;
      saved_bump_r <= '0;
      hold_count_r <= '0;
      status_r     <= '0;
      sign_r       <= '0;
    end else begin
      speed_now_r  <= speed_now_nxt;
      saved_obs_r  <= saved_obs_nxt;
      saved_stop_r <= saved_stop_nxt;
      saved_bump_r <= saved_bump_nxt;
      hold_count_r <= hold_count_nxt;
      status_r     <= status_nxt;
      sign_r       <= sign_nxt;
    end
  end

  assign res_speed = speed_now_nxt;

endmodule

### dv/detection_speed_governor_test.sv
// Self-checking testbench for the detection speed governor: random and directed streams.
`timescale 1ns / 1ps

module detection_speed_governor_test;
  import dsg_pkg::*;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam hold_count_t HOLD_ALL_ONES = '1;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PRESSURE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  detection_speed_governor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Governor state, advanced on every accepted beat, and register copies.
  logic [TICKS_W-1:0] lim_stop = STOP_HOLD_RESET;
  logic [TICKS_W-1:0] lim_bump = BUMP_HOLD_RESET;
  logic [SPEED_W-1:0] spd_bump = BUMP_SPEED_RESET;
  logic [SPEED_W-1:0] spd_low = LOW_SPEED_RESET;
  logic [SPEED_W-1:0] spd_normal = NORMAL_SPEED_RESET;
  logic [SPEED_W-1:0] gov_speed = SPEED_AT_RESET;
  logic [SPEED_W-1:0] gov_saved_obst = '0;
  logic [SPEED_W-1:0] gov_saved_stop = '0;
  logic [SPEED_W-1:0] gov_saved_bump = '0;
  hold_count_t gov_hold = '0;
  logic [1:0] gov_status = US_CLEAR;
  logic [2:0] gov_sign = SIGN_NONE;

  logic [SPEED_W-1:0] speeds_due[$];
  item_t pending_items[$];

  int unsigned mismatches = 0;
  int unsigned speeds_seen = 0;
  int unsigned beats_taken = 0;
  int unsigned reg_writes = 0;
  int unsigned useful_items = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned pressure_requests = 0;
  int unsigned pressure_served = 0;

  // Keeps the hold speed until the limit is reached, then falls back to the saved speed.
  function automatic logic [SPEED_W-1:0] hold_step(input logic [TICKS_W-1:0] limit,
                                                   input logic [SPEED_W-1:0] hold_spd,
                                                   input logic [SPEED_W-1:0] saved);
    logic [SPEED_W-1:0] kept;
    kept = saved;
    if (gov_speed != hold_spd && gov_hold == '0) kept = gov_speed;
    if (gov_hold < limit) begin
      gov_speed = hold_spd;
      if (gov_hold != HOLD_ALL_ONES) gov_hold = gov_hold + 1'b1;
    end else begin
      gov_speed = kept;
    end
    return kept;
  endfunction

  function automatic void tick_governor();
    if (gov_status == US_ABNORMAL) begin
      gov_speed = '0;
    end else if (gov_status == US_PEDESTRIAN) begin
      if (gov_speed != '0) gov_saved_obst = gov_speed;
      gov_speed = '0;
    end else if (gov_saved_obst == '0) begin
      case (gov_sign)
        SIGN_STOP:   gov_saved_stop = hold_step(lim_stop, '0, gov_saved_stop);
        SIGN_BUMP:   gov_saved_bump = hold_step(lim_bump, spd_bump, gov_saved_bump);
        SIGN_LOW:    gov_speed = spd_low;
        SIGN_NORMAL: gov_speed = spd_normal;
        default: ;
      endcase
    end else if (gov_status == US_CLEAR) begin
      gov_speed = gov_saved_obst;
      gov_saved_obst = '0;
    end
  endfunction

  function automatic void advance_governor(input item_t it);
    if (it.func == FUNC_STATUS) begin
      gov_status = it.us_status;
    end else if (it.func == FUNC_SIGN) begin
      gov_sign = it.sign_class;
      gov_hold = '0;
    end else if (it.func == FUNC_TICK) begin
      tick_governor();
      speeds_due.push_back(gov_speed);
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: offers queued items and records each accepted beat.
  int tx_gap = 0;
  always @(posedge clk) begin
    item_t taken, next_item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        taken.func = in_tuser;
        taken.us_status = in_tdata[1:0];
        taken.sign_class = in_tdata[4:2];
        advance_governor(taken);
        beats_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_item.func;
          in_tdata <= {3'b000, next_item.sign_class, next_item.us_status};
          if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) tx_gap = draw_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus a long hold-off on request.
  int rx_wait = 0;
  always @(posedge clk) begin
    if (pressure_served != pressure_requests) begin
      pressure_served++;
      rx_wait = PRESSURE_CYCLES;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) rx_wait = draw_gap();
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    logic [SPEED_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      speeds_seen++;
      if (speeds_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("speed beat %0d arrived with none expected", out_tdata);
      end else begin
        want = speeds_due.pop_front();
        if (out_tdata != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("speed mismatch on beat %0d: expected %0d, got %0d",
                     speeds_seen, want, out_tdata);
        end
      end
    end
  end

  // Register writes update the local copies.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STOP_HOLD:    lim_stop = cfg_data[TICKS_W-1:0];
        REG_BUMP_HOLD:    lim_bump = cfg_data[TICKS_W-1:0];
        REG_BUMP_SPEED:   spd_bump = cfg_data[SPEED_W-1:0];
        REG_LOW_SPEED:    spd_low = cfg_data[SPEED_W-1:0];
        REG_NORMAL_SPEED: spd_normal = cfg_data[SPEED_W-1:0];
        default: ;
      endcase
      reg_writes++;
    end
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [1:0] f, input logic [1:0] st, input logic [2:0] sg);
    item_t it;
    it.func = f;
    it.us_status = st;
    it.sign_class = sg;
    pending_items.push_back(it);
    if (f != FUNC_UNUSED) useful_items++;
  endtask

  // Ticks carry random content in the fields the block ignores.
  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) add_item(FUNC_TICK, 2'($urandom_range(3)), 3'($urandom_range(7)));
  endtask

  task automatic add_random_scenario();
    int pick;
    logic [2:0] sg;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if ($urandom_range(9) < 8) sg = 3'($urandom_range(1, 4));
      else if ($urandom_range(3) == 0) sg = SIGN_NONE;
      else sg = 3'($urandom_range(5, 7));
      add_item(FUNC_SIGN, 2'($urandom_range(3)), sg);
      add_ticks($urandom_range(1, 14));
    end else if (pick < 70) begin
      add_item(FUNC_STATUS, US_PEDESTRIAN, 3'($urandom_range(7)));
      add_ticks($urandom_range(1, 4));
      if ($urandom_range(1) == 1) begin
        add_item(FUNC_STATUS, US_IGNORED, 3'($urandom_range(7)));
        add_ticks($urandom_range(1, 2));
      end
      if ($urandom_range(3) == 0) add_item(FUNC_SIGN, 2'($urandom_range(3)), 3'($urandom_range(1, 4)));
      add_item(FUNC_STATUS, US_CLEAR, 3'($urandom_range(7)));
      add_ticks($urandom_range(1, 4));
    end else if (pick < 88) begin
      add_item(FUNC_STATUS, US_ABNORMAL, 3'($urandom_range(7)));
      add_ticks($urandom_range(1, 3));
      add_item(FUNC_STATUS, ($urandom_range(1) == 1) ? US_CLEAR : US_IGNORED, 3'($urandom_range(7)));
      add_ticks($urandom_range(1, 5));
    end else begin
      for (int i = $urandom_range(1, 3); i > 0; i--)
        add_item(2'($urandom_range(3)), 2'($urandom_range(3)), 3'($urandom_range(7)));
    end
  endtask

  // Waits until every item is taken and every speed has come back, then lets
  // any item without a result clear the pipeline.
  task automatic wait_drain();
    while (pending_items.size() != 0 || in_tvalid || speeds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] stop_t, input logic [15:0] bump_t,
                            input logic [15:0] bump_s, input logic [15:0] low_s,
                            input logic [15:0] norm_s);
    write_reg(REG_STOP_HOLD, stop_t);
    write_reg(REG_BUMP_HOLD, bump_t);
    write_reg(REG_BUMP_SPEED, bump_s);
    write_reg(REG_LOW_SPEED, low_s);
    write_reg(REG_NORMAL_SPEED, norm_s);
  endtask

  task automatic run_random_phase(input int unsigned n, input int unsigned tx_pct,
                                  input int unsigned rx_pct, input bit squeeze);
    int unsigned goal;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = useful_items + n;
    while (useful_items < goal) add_random_scenario();
    if (squeeze) pressure_requests++;
    wait_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset settings.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    add_ticks(1);
    add_item(FUNC_SIGN, US_CLEAR, SIGN_LOW);
    add_ticks(1);
    add_item(FUNC_SIGN, US_IGNORED, SIGN_NORMAL);
    add_ticks(1);
    add_item(FUNC_STATUS, US_PEDESTRIAN, 3'b111);
    add_ticks(2);
    // Ignored status while an obstacle speed is saved: the tick changes nothing.
    add_item(FUNC_STATUS, US_IGNORED, SIGN_NONE);
    add_ticks(1);
    add_item(FUNC_STATUS, US_CLEAR, SIGN_NONE);
    add_ticks(1);
    add_item(FUNC_STATUS, US_ABNORMAL, SIGN_STOP);
    add_ticks(1);
    // Ignored status with nothing saved lets the sign rules run.
    add_item(FUNC_STATUS, US_IGNORED, SIGN_NONE);
    add_ticks(1);
    add_item(FUNC_SIGN, US_CLEAR, SIGN_BUMP);
    add_ticks(2);
    add_item(FUNC_SIGN, US_CLEAR, SIGN_STOP);
    add_ticks(1);
    add_item(FUNC_UNUSED, 2'b11, 3'b111);
    add_item(FUNC_SIGN, US_CLEAR, 3'd7);
    add_ticks(1);
    add_item(FUNC_SIGN, US_CLEAR, SIGN_NONE);
    add_ticks(1);
    wait_drain();

    // A limit lowered below the running count ends the hold at once.
    set_config(16'd20, 16'd4000, 16'd30, 16'd36, 16'd60);
    add_item(FUNC_SIGN, US_CLEAR, SIGN_NORMAL);
    add_ticks(1);
    add_item(FUNC_SIGN, US_CLEAR, SIGN_STOP);
    add_ticks(6);
    wait_drain();
    write_reg(REG_STOP_HOLD, 16'd2);
    add_ticks(3);
    wait_drain();

    set_config(16'd3, 16'd5, 16'd30, 16'd36, 16'd60);
    run_random_phase(150, 0, 0, 1'b0);

    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random_phase(120, 20, 20, 1'b0);

    set_config(16'hFFFF, 16'hFFFF, 16'hFF, 16'hFF, 16'hFF);
    run_random_phase(120, 40, 30, 1'b0);

    // Full-width data to the speed registers exercises their masking.
    set_config(16'($urandom_range(12)), 16'($urandom_range(12)), 16'($urandom),
               16'($urandom), 16'($urandom));
    run_random_phase(180, 10, 50, 1'b1);

    set_config(16'($urandom_range(12)), 16'($urandom_range(12)), 16'($urandom_range(255)),
               16'($urandom_range(255)), 16'($urandom_range(255)));
    write_reg(CFG_INDEX_W'($urandom_range(5, 7)), 16'($urandom));
    run_random_phase(150, 25, 25, 1'b0);

    mismatches += speeds_due.size();
    $display("Run covered %0d input beats, %0d speed results and %0d register writes,",
             beats_taken, speeds_seen, reg_writes);
    $display("across default, extreme and random settings with back-pressure; %0d failures.",
             mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
